>>> hdl/qbv_pkg.sv
// Shared constants, types and helpers for the shortest-arc quaternion pipeline.
package qbv_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 15;
    localparam int OUT_W       = 16;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int LW   = 2 * COORD_WIDTH + 2;
    localparam int DOTW = LW + 1;
    localparam int CRW  = PW + 1;
    localparam int LL   = (LW + 1) / 2;
    localparam int LH   = LW - LL;
    localparam int WW   = LW + 2;
    localparam int SW   = 2 * WW;
    localparam int NW   = WW;
    localparam int QB   = FRAC_BITS + 1;
    localparam int N1   = LW;
    localparam int N2   = WW;

    localparam int ST_DIFF = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_PP   = 3;
    localparam int ST_P    = 4;
    localparam int ST_SQ1  = 5;
    localparam int ST_KD   = ST_SQ1 + N1;
    localparam int ST_S    = ST_KD + 1;
    localparam int ST_SQ2  = ST_S + 1;
    localparam int ST_DV0  = ST_SQ2 + N2;
    localparam int ST_DIV  = ST_DV0 + 1;
    localparam int ST_OUT  = ST_DIV + QB;
    localparam int NS      = ST_OUT + 1;

    localparam logic [OUT_W-1:0] ONE_Q = (FRAC_BITS >= OUT_W - 1) ?
        {1'b0, {(OUT_W-1){1'b1}}} : (OUT_W'(1) << FRAC_BITS);

    typedef enum logic [1:0] {
        CASE_NORMAL = 2'd0,
        CASE_ANTI   = 2'd1,
        CASE_ZERO   = 2'd2
    } t_case;

    typedef struct packed {
        logic signed [DOTW-1:0] dot;
        logic signed [CRW-1:0]  cx;
        logic signed [CRW-1:0]  cy;
        logic signed [CRW-1:0]  cz;
        logic [2*LW-1:0]        p;
        logic                   zero;
        logic                   anti;
    } t_side1;

    typedef struct packed {
        logic [WW-1:0]         w;
        logic signed [CRW-1:0] cx;
        logic signed [CRW-1:0] cy;
        logic signed [CRW-1:0] cz;
        logic                  zero;
        logic                  anti;
    } t_side2;

    typedef struct packed {
        logic       zero;
        logic       anti;
        logic [3:0] neg;
    } t_side3;

    function automatic logic [OUT_W-1:0] sat_q(input logic [QB:0] mag, input logic neg);
        logic [31:0] m;
        m = 32'(mag);
        if (neg) begin
            if (m > 32'(2 ** (OUT_W - 1))) sat_q = {1'b1, {(OUT_W-1){1'b0}}};
            else sat_q = OUT_W'(32'd0 - m);
        end else begin
            if (m > 32'(2 ** (OUT_W - 1) - 1)) sat_q = {1'b0, {(OUT_W-1){1'b1}}};
            else sat_q = OUT_W'(m);
        end
    endfunction

endpackage

>>> hdl/rotation_quaternion_between_vectors.sv
// Shortest-arc rotation quaternion between two vectors, fully pipelined.
// Depth: NS = 95 register stages from input acceptance to o_valid.
// Throughput: one beat per cycle unless i_ready stalls the output; two 1-bit-per-stage
//   square roots and a 16-stage restoring divider per component set the depth.
// Each stage advances when empty or when the stage after it advances, so bubbles close up.
// Reset clears all stage valid bits; data registers are not reset.
module rotation_quaternion_between_vectors
    import qbv_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_z,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_z,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [OUT_W-1:0]       o_quat_w,
    output logic signed [OUT_W-1:0]       o_quat_i,
    output logic signed [OUT_W-1:0]       o_quat_j,
    output logic signed [OUT_W-1:0]       o_quat_k,
    output logic [1:0]                    o_case_code
);

    logic [NS-1:0] r_v;
    logic [NS-1:0] n_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
        n_v[0] = w_en[0] ? i_valid : r_v[0];
        for (int i = 1; i < NS; i++) begin
            n_v[i] = w_en[i] ? r_v[i-1] : r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];

    logic signed [COORD_WIDTH-1:0] w_p1 [0:2];
    logic signed [COORD_WIDTH-1:0] w_p2 [0:2];
    logic signed [COORD_WIDTH-1:0] w_pv [0:2];

    always_comb begin
        w_p1[0] = i_first_x;  w_p1[1] = i_first_y;  w_p1[2] = i_first_z;
        w_p2[0] = i_second_x; w_p2[1] = i_second_y; w_p2[2] = i_second_z;
        w_pv[0] = i_vertex_x; w_pv[1] = i_vertex_y; w_pv[2] = i_vertex_z;
    end

    logic signed [DW-1:0] r_a [0:2];
    logic signed [DW-1:0] r_b [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DIFF]) begin
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= DW'(w_p1[i]) - DW'(w_pv[i]);
                r_b[i] <= DW'(w_p2[i]) - DW'(w_pv[i]);
            end
        end
    end

    logic signed [PW-1:0] r_sqa [0:2];
    logic signed [PW-1:0] r_sqb [0:2];
    logic signed [PW-1:0] r_dp  [0:2];
    logic signed [PW-1:0] r_cp  [0:5];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            for (int i = 0; i < 3; i++) begin
                r_sqa[i] <= r_a[i] * r_a[i];
                r_sqb[i] <= r_b[i] * r_b[i];
                r_dp[i]  <= r_a[i] * r_b[i];
            end
            r_cp[0] <= r_a[1] * r_b[2];
            r_cp[1] <= r_a[2] * r_b[1];
            r_cp[2] <= r_a[2] * r_b[0];
            r_cp[3] <= r_a[0] * r_b[2];
            r_cp[4] <= r_a[0] * r_b[1];
            r_cp[5] <= r_a[1] * r_b[0];
        end
    end

    logic [LW-1:0]          r_la;
    logic [LW-1:0]          r_lb;
    logic signed [DOTW-1:0] r_dot;
    logic signed [CRW-1:0]  r_c [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_la  <= LW'($unsigned(r_sqa[0])) + LW'($unsigned(r_sqa[1]))
                   + LW'($unsigned(r_sqa[2]));
            r_lb  <= LW'($unsigned(r_sqb[0])) + LW'($unsigned(r_sqb[1]))
                   + LW'($unsigned(r_sqb[2]));
            r_dot <= DOTW'(r_dp[0]) + DOTW'(r_dp[1]) + DOTW'(r_dp[2]);
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= CRW'(r_cp[2*i]) - CRW'(r_cp[2*i+1]);
            end
        end
    end

    logic [2*LL-1:0]        r_pp_ll;
    logic [LL+LH-1:0]       r_pp_lh;
    logic [LL+LH-1:0]       r_pp_hl;
    logic [2*LH-1:0]        r_pp_hh;
    logic signed [DOTW-1:0] r_pp_dot;
    logic signed [CRW-1:0]  r_pp_c [0:2];
    logic                   r_pp_zero;
    logic                   r_pp_anti;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PP]) begin
            r_pp_ll   <= r_la[LL-1:0] * r_lb[LL-1:0];
            r_pp_lh   <= r_la[LL-1:0] * r_lb[LW-1:LL];
            r_pp_hl   <= r_la[LW-1:LL] * r_lb[LL-1:0];
            r_pp_hh   <= r_la[LW-1:LL] * r_lb[LW-1:LL];
            r_pp_dot  <= r_dot;
            r_pp_c    <= r_c;
            r_pp_zero <= (r_la == '0) || (r_lb == '0);
            r_pp_anti <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0) && r_dot[DOTW-1];
        end
    end

    t_side1 r_p_side;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_P]) begin
            r_p_side.p    <= (2*LW)'(r_pp_ll) + ((2*LW)'(r_pp_lh) << LL)
                           + ((2*LW)'(r_pp_hl) << LL) + ((2*LW)'(r_pp_hh) << (2*LL));
            r_p_side.dot  <= r_pp_dot;
            r_p_side.cx   <= r_pp_c[0];
            r_p_side.cy   <= r_pp_c[1];
            r_p_side.cz   <= r_pp_c[2];
            r_p_side.zero <= r_pp_zero;
            r_p_side.anti <= r_pp_anti;
        end
    end

    logic [N1-1:0]   r_q1_root [0:N1-1];
    logic [N1+1:0]   r_q1_rem  [0:N1-1];
    logic [2*N1-1:0] r_q1_rad  [0:N1-1];
    t_side1          r_q1_side [0:N1-1];

    for (genvar j = 0; j < N1; j++) begin : g_sq1
        logic [N1-1:0]   root_in;
        logic [N1+1:0]   rem_in;
        logic [2*N1-1:0] rad_in;
        t_side1          side_in;
        logic [N1+1:0]   rem_sh;
        logic [N1+1:0]   trial;
        logic            ge;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = r_p_side.p;
            assign side_in = r_p_side;
        end else begin : g_next
            assign root_in = r_q1_root[j-1];
            assign rem_in  = r_q1_rem[j-1];
            assign rad_in  = r_q1_rad[j-1];
            assign side_in = r_q1_side[j-1];
        end

        assign rem_sh = {rem_in[N1-1:0], rad_in[2*N1-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (w_en[ST_SQ1+j]) begin
                r_q1_root[j] <= {root_in[N1-2:0], ge};
                r_q1_rem[j]  <= ge ? rem_sh - trial : rem_sh;
                r_q1_rad[j]  <= rad_in << 2;
                r_q1_side[j] <= side_in;
            end
        end
    end

    t_side1        w_s1;
    logic [LW-1:0] w_k;
    logic [LW-1:0] w_dmag;

    assign w_s1   = r_q1_side[N1-1];
    assign w_k    = r_q1_root[N1-1];
    assign w_dmag = LW'(w_s1.dot[DOTW-1] ? -w_s1.dot : w_s1.dot);

    logic [2*LL-1:0]  r_kd_ll;
    logic [LL+LH-1:0] r_kd_lh;
    logic [LL+LH-1:0] r_kd_hl;
    logic [2*LH-1:0]  r_kd_hh;
    logic             r_kd_neg;
    logic [2*LW-1:0]  r_kd_p;
    logic [N1+1:0]    r_kd_rem;
    t_side2           r_kd_side;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_KD]) begin
            r_kd_ll        <= w_k[LL-1:0] * w_dmag[LL-1:0];
            r_kd_lh        <= w_k[LL-1:0] * w_dmag[LW-1:LL];
            r_kd_hl        <= w_k[LW-1:LL] * w_dmag[LL-1:0];
            r_kd_hh        <= w_k[LW-1:LL] * w_dmag[LW-1:LL];
            r_kd_neg       <= w_s1.dot[DOTW-1];
            r_kd_p         <= w_s1.p;
            r_kd_rem       <= r_q1_rem[N1-1];
            r_kd_side.w    <= WW'(w_k) + WW'($unsigned(WW'(w_s1.dot)));
            r_kd_side.cx   <= w_s1.cx;
            r_kd_side.cy   <= w_s1.cy;
            r_kd_side.cz   <= w_s1.cz;
            r_kd_side.zero <= w_s1.zero;
            r_kd_side.anti <= w_s1.anti;
        end
    end

    logic [2*LW-1:0] w_kd;
    logic [SW:0]     w_base;
    logic [SW:0]     w_kd2;
    logic [SW:0]     w_s;

    always_comb begin
        w_kd   = (2*LW)'(r_kd_ll) + ((2*LW)'(r_kd_lh) << LL)
               + ((2*LW)'(r_kd_hl) << LL) + ((2*LW)'(r_kd_hh) << (2*LL));
        w_base = ((SW+1)'(r_kd_p) << 1) - (SW+1)'(r_kd_rem);
        w_kd2  = (SW+1)'(w_kd) << 1;
        w_s    = r_kd_neg ? w_base - w_kd2 : w_base + w_kd2;
    end

    logic [SW-1:0] r_s_rad;
    t_side2        r_s_side;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_S]) begin
            r_s_rad  <= w_s[SW-1:0];
            r_s_side <= r_kd_side;
        end
    end

    logic [N2-1:0]   r_q2_root [0:N2-1];
    logic [N2+1:0]   r_q2_rem  [0:N2-1];
    logic [2*N2-1:0] r_q2_rad  [0:N2-1];
    t_side2          r_q2_side [0:N2-1];

    for (genvar j = 0; j < N2; j++) begin : g_sq2
        logic [N2-1:0]   root_in;
        logic [N2+1:0]   rem_in;
        logic [2*N2-1:0] rad_in;
        t_side2          side_in;
        logic [N2+1:0]   rem_sh;
        logic [N2+1:0]   trial;
        logic            ge;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = '0;
            assign rad_in  = r_s_rad;
            assign side_in = r_s_side;
        end else begin : g_next
            assign root_in = r_q2_root[j-1];
            assign rem_in  = r_q2_rem[j-1];
            assign rad_in  = r_q2_rad[j-1];
            assign side_in = r_q2_side[j-1];
        end

        assign rem_sh = {rem_in[N2-1:0], rad_in[2*N2-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (w_en[ST_SQ2+j]) begin
                r_q2_root[j] <= {root_in[N2-2:0], ge};
                r_q2_rem[j]  <= ge ? rem_sh - trial : rem_sh;
                r_q2_rad[j]  <= rad_in << 2;
                r_q2_side[j] <= side_in;
            end
        end
    end

    t_side2        w_s2;
    logic [N2-1:0] w_n;

    assign w_s2 = r_q2_side[N2-1];
    assign w_n  = r_q2_root[N2-1];

    logic [3:0][NW:0] r_d0_mag;
    logic [NW-1:0]    r_d0_n;
    t_side3           r_d0_side;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_DV0]) begin
            r_d0_mag[0]    <= (NW+1)'(w_s2.w);
            r_d0_mag[1]    <= (NW+1)'($unsigned(w_s2.cx[CRW-1] ? -w_s2.cx : w_s2.cx));
            r_d0_mag[2]    <= (NW+1)'($unsigned(w_s2.cy[CRW-1] ? -w_s2.cy : w_s2.cy));
            r_d0_mag[3]    <= (NW+1)'($unsigned(w_s2.cz[CRW-1] ? -w_s2.cz : w_s2.cz));
            r_d0_n         <= (w_n == '0) ? NW'(1) : NW'(w_n);
            r_d0_side.zero <= w_s2.zero;
            r_d0_side.anti <= w_s2.anti;
            r_d0_side.neg  <= {w_s2.cz[CRW-1], w_s2.cy[CRW-1], w_s2.cx[CRW-1], 1'b0};
        end
    end

    logic [3:0][NW:0]   r_dv_rem  [0:QB-1];
    logic [3:0][QB-1:0] r_dv_q    [0:QB-1];
    logic [NW-1:0]      r_dv_n    [0:QB-1];
    t_side3             r_dv_side [0:QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [3:0][NW:0]   rem_in;
        logic [3:0][QB-1:0] q_in;
        logic [NW-1:0]      n_in;
        t_side3             side_in;
        logic [3:0][NW:0]   rin;
        logic [3:0][NW:0]   rout;
        logic [3:0]         ge;

        if (j == 0) begin : g_first
            assign q_in    = '0;
            assign n_in    = r_d0_n;
            assign side_in = r_d0_side;
            assign rem_in  = r_d0_mag;
            assign rin     = rem_in;
        end else begin : g_next
            assign q_in    = r_dv_q[j-1];
            assign n_in    = r_dv_n[j-1];
            assign side_in = r_dv_side[j-1];
            assign rem_in  = r_dv_rem[j-1];
            for (genvar l = 0; l < 4; l++) begin : g_sh
                assign rin[l] = {rem_in[l][NW-1:0], 1'b0};
            end
        end

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                ge[l]   = rin[l] >= {1'b0, n_in};
                rout[l] = ge[l] ? rin[l] - {1'b0, n_in} : rin[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[ST_DIV+j]) begin
                r_dv_rem[j]  <= rout;
                r_dv_n[j]    <= n_in;
                r_dv_side[j] <= side_in;
                for (int l = 0; l < 4; l++) begin
                    r_dv_q[j][l] <= {q_in[l][QB-2:0], ge[l]};
                end
            end
        end
    end

    logic [3:0][OUT_W-1:0] w_qs;
    t_side3                w_s3;

    assign w_s3 = r_dv_side[QB-1];

    always_comb begin
        logic [NW+1:0] rem2;
        logic          rnd;
        logic [QB:0]   qr;
        for (int l = 0; l < 4; l++) begin
            rem2    = {r_dv_rem[QB-1][l], 1'b0};
            rnd     = rem2 >= (NW+2)'(r_dv_n[QB-1]);
            qr      = (QB+1)'(r_dv_q[QB-1][l]) + (QB+1)'(rnd);
            w_qs[l] = sat_q(qr, w_s3.neg[l]);
        end
    end

    logic [OUT_W-1:0] r_o_w;
    logic [OUT_W-1:0] r_o_i;
    logic [OUT_W-1:0] r_o_j;
    logic [OUT_W-1:0] r_o_k;
    t_case            r_o_case;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            if (w_s3.zero) begin
                r_o_w    <= ONE_Q;
                r_o_i    <= '0;
                r_o_j    <= '0;
                r_o_k    <= '0;
                r_o_case <= CASE_ZERO;
            end else if (w_s3.anti) begin
                r_o_w    <= '0;
                r_o_i    <= '0;
                r_o_j    <= ONE_Q;
                r_o_k    <= '0;
                r_o_case <= CASE_ANTI;
            end else begin
                r_o_w    <= w_qs[0];
                r_o_i    <= w_qs[1];
                r_o_j    <= w_qs[2];
                r_o_k    <= w_qs[3];
                r_o_case <= CASE_NORMAL;
            end
        end
    end

    assign o_quat_w    = $signed(r_o_w);
    assign o_quat_i    = $signed(r_o_i);
    assign o_quat_j    = $signed(r_o_j);
    assign o_quat_k    = $signed(r_o_k);
    assign o_case_code = r_o_case;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[0])
        else $error("accepted beat did not enter first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ST_SQ2] && !w_en[ST_SQ2] |=> r_v[ST_SQ2] && $stable(r_q2_root[0]))
        else $error("stalled stage lost its beat");

    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_o_case == CASE_ZERO |-> r_o_w == ONE_Q && r_o_i == '0
            && r_o_j == '0 && r_o_k == '0)
        else $error("zero-length result is not identity");

    a_anti_half_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_o_case == CASE_ANTI |-> r_o_w == '0 && r_o_j == ONE_Q)
        else $error("antiparallel result is not a half turn");

    a_normal_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_o_case == CASE_NORMAL |-> !r_o_w[OUT_W-1])
        else $error("scalar part negative on normal result");

endmodule
